/* rtl/term_vector_cosine_similarity_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the term vector cosine similarity core
// Shared property shapes used by the port checker.
// ---------------------------------------------------------------------------
`ifndef TERM_VECTOR_COSINE_SIMILARITY_CORE_DEFINES_SVH
`define TERM_VECTOR_COSINE_SIMILARITY_CORE_DEFINES_SVH

// same-cycle implication, idle in reset
`define TVCS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tvcs check failed: same-cycle rule");

// next-cycle implication, idle in reset
`define TVCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tvcs check failed: next-cycle rule");

`endif

/* rtl/tvcs_pkg.sv */
// ---------------------------------------------------------------------------
// tvcs_pkg
// Widths, constants and shared types of the cosine similarity core.
// ---------------------------------------------------------------------------
package tvcs_pkg;

  // input counts and products
  localparam int COUNT_BITS = 16;
  localparam int PROD_W     = 2 * COUNT_BITS;

  // pair accumulators, saturating
  localparam int ACC_W  = 48;
  localparam int ACCX_W = ACC_W + 1;

  // Q1.16 results and set sum
  localparam int Q_W    = 17;
  localparam int SUM_W  = 25;
  localparam int SUMX_W = SUM_W + 1;
  localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);

  // document count register and average divisor
  localparam int DOCS_W   = 9;
  localparam int MAX_DOCS = 256;
  localparam int DIV_W    = $clog2(MAX_DOCS);
  localparam logic [DOCS_W-1:0] DOC_TOTAL_RST = DOCS_W'(2);
  localparam logic [DIV_W-1:0]  DIV_MAX = DIV_W'(MAX_DOCS - 1);

  // square root: radicand is norm scaled by 2^16, root has 8 fraction bits
  localparam int RAD_W  = 64;
  localparam int ROOT_W = RAD_W / 2;
  localparam int SREM_W = ROOT_W + 2;
  localparam int SRSH_W = SREM_W + 2;

  // cosine division: dot * 2^32 / (ra * rb)
  localparam int DEN_W  = 2 * ROOT_W;
  localparam int DREM_W = DEN_W + 1;

  // iteration counts of the back-end sequencer
  localparam int STEP_W = 7;
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(ACC_W + 32 - 1);
  localparam logic [STEP_W-1:0] AVG_LAST  = STEP_W'(SUM_W - 1);

  // pair queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // one finished pair, handed from front to back
  typedef struct packed {
    logic [ACC_W-1:0] dot;
    logic [ACC_W-1:0] own_norm;
    logic [ACC_W-1:0] other_norm;
    logic             last_doc;
  } pair_t;

  typedef struct packed {
    logic  valid;
    pair_t data;
  } q_push_t;

  typedef struct packed {
    logic  valid;
    pair_t data;
  } q_head_t;

  // one digit step of the square root
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic [SREM_W-1:0] rem;
  } sqrt_st_t;

  function automatic sqrt_st_t sqrt_step(sqrt_st_t cur);
    sqrt_st_t          nxt;
    logic [SRSH_W-1:0] r_sh;
    logic [SRSH_W-1:0] trial;
    r_sh  = {cur.rem, cur.rad[RAD_W-1 -: 2]};
    trial = {2'b00, cur.root, 2'b01};
    nxt.rad = {cur.rad[RAD_W-3:0], 2'b00};
    if (r_sh >= trial) begin
      nxt.rem  = SREM_W'(r_sh - trial);
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = r_sh[SREM_W-1:0];
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

/* rtl/tvcs_ifs.sv */
// ---------------------------------------------------------------------------
// tvcs channel interfaces
// Term input, result output and configuration write channels.
// ---------------------------------------------------------------------------
interface tvcs_in_if
  import tvcs_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] own_count;
  logic [COUNT_BITS-1:0] other_count;
  logic                  last_term;
  logic                  last_doc;

  modport source (output valid, own_count, other_count, last_term, last_doc, input ready);
  modport sink   (input valid, own_count, other_count, last_term, last_doc, output ready);
endinterface

interface tvcs_out_if
  import tvcs_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [Q_W-1:0] cosine;
  logic           zero_norm;
  logic [Q_W-1:0] average;
  logic           average_valid;

  modport source (output valid, cosine, zero_norm, average, average_valid, input ready);
  modport sink   (input valid, cosine, zero_norm, average, average_valid, output ready);
endinterface

interface tvcs_cfg_if
  import tvcs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DOCS_W-1:0] doc_total;

  modport source (output valid, doc_total, input ready);
  modport sink   (input valid, doc_total, output ready);
endinterface

/* rtl/tvcs_front.sv */
// ---------------------------------------------------------------------------
// tvcs_front
// Takes one term item per cycle while the queue has room, registers the three products and
// accumulates them; a last term pushes the finished pair to the queue.
// ---------------------------------------------------------------------------
module tvcs_front
  import tvcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  tvcs_in_if.sink           terms,
  input  logic [QCNT_W-1:0] q_level,
  output q_push_t           q_push
);

  logic              a_valid;
  logic              a_last_term;
  logic              a_last_doc;
  logic [PROD_W-1:0] p_dot;
  logic [PROD_W-1:0] p_own;
  logic [PROD_W-1:0] p_oth;

  logic [ACC_W-1:0]  acc_dot;
  logic [ACC_W-1:0]  acc_own;
  logic [ACC_W-1:0]  acc_oth;

  logic [ACCX_W-1:0] s_dot;
  logic [ACCX_W-1:0] s_own;
  logic [ACCX_W-1:0] s_oth;
  logic [ACC_W-1:0]  n_dot;
  logic [ACC_W-1:0]  n_own;
  logic [ACC_W-1:0]  n_oth;
  logic              fire;
  logic              a_close;

  // room for the pair in the product stage and one more
  assign a_close     = a_valid & a_last_term;
  assign terms.ready = (q_level + QCNT_W'(a_close)) < QCNT_W'(QUEUE_DEPTH);
  assign fire        = terms.valid & terms.ready;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= fire;
    end
    if (fire) begin
      a_last_term <= terms.last_term;
      a_last_doc  <= terms.last_doc;
      p_dot <= PROD_W'(terms.own_count) * PROD_W'(terms.other_count);
      p_own <= PROD_W'(terms.own_count) * PROD_W'(terms.own_count);
      p_oth <= PROD_W'(terms.other_count) * PROD_W'(terms.other_count);
    end
  end

  // saturating sums
  always_comb begin
    s_dot = ACCX_W'(acc_dot) + ACCX_W'(p_dot);
    s_own = ACCX_W'(acc_own) + ACCX_W'(p_own);
    s_oth = ACCX_W'(acc_oth) + ACCX_W'(p_oth);
    n_dot = s_dot[ACC_W] ? '1 : s_dot[ACC_W-1:0];
    n_own = s_own[ACC_W] ? '1 : s_own[ACC_W-1:0];
    n_oth = s_oth[ACC_W] ? '1 : s_oth[ACC_W-1:0];
  end

  // accumulators, cleared after each pair
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_dot <= '0;
      acc_own <= '0;
      acc_oth <= '0;
    end else if (a_valid) begin
      if (a_last_term) begin
        acc_dot <= '0;
        acc_own <= '0;
        acc_oth <= '0;
      end else begin
        acc_dot <= n_dot;
        acc_own <= n_own;
        acc_oth <= n_oth;
      end
    end
  end

  // finished pair to the queue
  always_comb begin
    q_push.valid           = a_close;
    q_push.data.dot        = n_dot;
    q_push.data.own_norm   = n_own;
    q_push.data.other_norm = n_oth;
    q_push.data.last_doc   = a_last_doc;
  end

endmodule

/* rtl/tvcs_queue.sv */
// ---------------------------------------------------------------------------
// tvcs_queue
// Short FIFO of finished pairs between the front and the back.
// ---------------------------------------------------------------------------
module tvcs_queue
  import tvcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  q_push_t           q_push,
  input  logic              pop,
  output q_head_t           head,
  output logic [QCNT_W-1:0] level
);

  pair_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              do_pop;

  assign do_pop = pop & (level != '0);

  // slot write
  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      slots[wr_ptr] <= q_push.data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (q_push.valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({q_push.valid, do_pop})
        2'b10:   level <= level + QCNT_W'(1);
        2'b01:   level <= level - QCNT_W'(1);
        default: level <= level;
      endcase
    end
  end

  assign head.valid = (level != '0);
  assign head.data  = slots[rd_ptr];

endmodule

/* rtl/tvcs_back.sv */
// ---------------------------------------------------------------------------
// tvcs_back
// Per-pair sequencer: two digit-serial square roots, one multiply,
// a bit-serial cosine divide (all skipped on a zero norm), the set sum,
// the average divide on the last pair of a set, then the result register.
// ---------------------------------------------------------------------------
module tvcs_back
  import tvcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_head_t     head,
  output logic        pop,
  tvcs_out_if.source  results,
  tvcs_cfg_if.sink    cfg
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQRT = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_AVG  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]        state;
  logic [STEP_W-1:0] step;
  logic [DOCS_W-1:0] doc_total;
  logic [SUM_W-1:0]  cos_sum;

  // job registers
  logic              last_doc;
  logic              zero;
  logic [ACC_W-1:0]  nshift;
  sqrt_st_t          sq_a;
  sqrt_st_t          sq_b;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  drem;
  logic [DEN_W-1:0]  quo;
  logic [Q_W-1:0]    cos_r;
  logic [SUM_W-1:0]  dvd;
  logic [DIV_W-1:0]  adiv;
  logic [DIV_W-1:0]  arem;

  // output register
  logic              out_valid;
  logic [Q_W-1:0]    out_cos;
  logic              out_zero;
  logic [Q_W-1:0]    out_avg;
  logic              out_avg_valid;

  // combinational helpers
  logic [DREM_W-1:0] d_sh;
  logic [Q_W-1:0]    cos_val;
  logic [SUMX_W-1:0] sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic [DOCS_W-1:0] dm1;
  logic [DIV_W-1:0]  div_val;
  logic [DIV_W:0]    a_sh;
  logic [DIV_W:0]    a_dif;
  logic              a_bit;
  logic [Q_W-1:0]    avg_val;
  logic              out_free;

  assign cfg.ready = 1'b1;
  assign pop       = (state == S_IDLE) & head.valid;
  assign out_free  = ~out_valid | results.ready;

  // datapath helpers
  always_comb begin
    d_sh    = {drem, nshift[ACC_W-1]};
    cos_val = (quo > DEN_W'(ONE_Q16)) ? ONE_Q16 : quo[Q_W-1:0];
    sum_ext = SUMX_W'(cos_sum) + SUMX_W'(cos_val);
    sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    dm1     = doc_total - DOCS_W'(1);
    if (doc_total <= DOCS_W'(1)) begin
      div_val = DIV_W'(1);
    end else if (dm1 > DOCS_W'(DIV_MAX)) begin
      div_val = DIV_MAX;
    end else begin
      div_val = dm1[DIV_W-1:0];
    end
    a_sh    = {arem, dvd[SUM_W-1]};
    a_bit   = (a_sh >= {1'b0, adiv});
    a_dif   = a_sh - {1'b0, adiv};
    avg_val = (dvd > SUM_W'(ONE_Q16)) ? ONE_Q16 : dvd[Q_W-1:0];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      doc_total <= DOC_TOTAL_RST;
    end else if (cfg.valid) begin
      doc_total <= cfg.doc_total;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      cos_sum   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          step <= '0;
          if (head.valid) begin
            if ((head.data.own_norm == '0) || (head.data.other_norm == '0)) begin
              state <= S_SUM;
            end else begin
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          step <= step + STEP_W'(1);
          if (step == SQRT_LAST) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          step <= step + STEP_W'(1);
          if (step == DIV_LAST) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          step <= '0;
          if (last_doc) begin
            cos_sum <= '0;
            state   <= S_AVG;
          end else begin
            cos_sum <= sum_sat;
            state   <= S_OUT;
          end
        end
        S_AVG: begin
          step <= step + STEP_W'(1);
          if (step == AVG_LAST) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result valid flag: set on load, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        last_doc <= head.data.last_doc;
        zero     <= (head.data.own_norm == '0) || (head.data.other_norm == '0);
        nshift   <= head.data.dot;
        sq_a     <= '{rad: {head.data.own_norm, 16'h0000}, root: '0, rem: '0};
        sq_b     <= '{rad: {head.data.other_norm, 16'h0000}, root: '0, rem: '0};
        quo      <= '0;
      end
      S_SQRT: begin
        sq_a <= sqrt_step(sq_a);
        sq_b <= sqrt_step(sq_b);
      end
      S_MUL: begin
        den  <= DEN_W'(sq_a.root) * DEN_W'(sq_b.root);
        drem <= '0;
      end
      S_DIV: begin
        nshift <= {nshift[ACC_W-2:0], 1'b0};
        if (d_sh >= {1'b0, den}) begin
          drem <= DEN_W'(d_sh - {1'b0, den});
          quo  <= {quo[DEN_W-2:0], 1'b1};
        end else begin
          drem <= d_sh[DEN_W-1:0];
          quo  <= {quo[DEN_W-2:0], 1'b0};
        end
      end
      S_SUM: begin
        cos_r <= cos_val;
        dvd   <= sum_sat;
        adiv  <= div_val;
        arem  <= '0;
      end
      S_AVG: begin
        arem <= a_bit ? a_dif[DIV_W-1:0] : a_sh[DIV_W-1:0];
        dvd  <= {dvd[SUM_W-2:0], a_bit};
      end
      S_OUT: begin
        if (out_free) begin
          out_cos       <= cos_r;
          out_zero      <= zero;
          out_avg       <= last_doc ? avg_val : '0;
          out_avg_valid <= last_doc;
        end
      end
      default: begin
        quo <= quo;
      end
    endcase
  end

  assign results.valid         = out_valid;
  assign results.cosine        = out_cos;
  assign results.zero_norm     = out_zero;
  assign results.average       = out_avg;
  assign results.average_valid = out_avg_valid;

endmodule

/* rtl/term_vector_cosine_similarity_core.sv */
// ---------------------------------------------------------------------------
// term_vector_cosine_similarity_core
// Cosine similarity of term-count vectors, Q1.16 per pair and set average.
// ---------------------------------------------------------------------------
// The front takes one term item per clock while the queue has room and
// accumulates the dot product and both squared norms; a last-term item
// closes a pair, which waits in a four-entry queue. The back handles one
// pair at a time and takes the next from the queue only when idle: 32
// square-root steps, one multiply, 80 divide steps, the sum and the
// output, with 25 average steps more when the pair closes the document
// set; a pair with a zero norm goes straight to the sum. When the queue
// has no room, the term input waits. doc_total may only be written
// while the block is idle; it resets to 2.
// ---------------------------------------------------------------------------
module term_vector_cosine_similarity_core
  import tvcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tvcs_in_if.sink     terms,
  tvcs_out_if.source  results,
  tvcs_cfg_if.sink    cfg
);

  q_push_t           q_push;
  q_head_t           q_head;
  logic [QCNT_W-1:0] q_level;
  logic              q_pop;

  // term intake and accumulation
  tvcs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .terms   (terms),
    .q_level (q_level),
    .q_push  (q_push)
  );

  // pair queue
  tvcs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .pop    (q_pop),
    .head   (q_head),
    .level  (q_level)
  );

  // per-pair arithmetic and result register
  tvcs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .pop     (q_pop),
    .results (results),
    .cfg     (cfg)
  );

endmodule

/* rtl/tvcs_checker.sv */
// ---------------------------------------------------------------------------
// tvcs_checker
// Port-level checks of the cosine similarity core, bound to the top level.
// ---------------------------------------------------------------------------
`include "term_vector_cosine_similarity_core_defines.svh"

module tvcs_checker
  import tvcs_pkg::*;
(
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input logic [Q_W-1:0] cosine,
  input logic           zero_norm,
  input logic [Q_W-1:0] average,
  input logic           average_valid
);

  // whole result item as one vector
  logic [2*Q_W+1:0] out_item;

  assign out_item = {cosine, zero_norm, average, average_valid};

  // a stalled result holds
  `TVCS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item))

  // zero norm forces a zero cosine
  `TVCS_ASSERT_IMPLY(a_zero_cos, clk, rst, out_valid && zero_norm, cosine == '0)

  // average only on the result that closes the set
  `TVCS_ASSERT_IMPLY(a_avg_zero, clk, rst, out_valid && !average_valid, average == '0)

  // both fractions stay at or below one
  `TVCS_ASSERT_IMPLY(a_q16_range, clk, rst, out_valid, (cosine <= ONE_Q16) && (average <= ONE_Q16))

endmodule

bind term_vector_cosine_similarity_core tvcs_checker u_tvcs_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .cosine        (results.cosine),
  .zero_norm     (results.zero_norm),
  .average       (results.average),
  .average_valid (results.average_valid)
);
